FILE: rtl/mwt_pkg.sv
// ----------------------------------------------------------------------------
// Median window converter package
// Shared sizes, item and control types, and fixed-point constants for the
// sliding-window median and dissolved-solids conversion.
// ----------------------------------------------------------------------------
package mwt_pkg;

  // Window geometry
  localparam int WINDOW_LEN = 30;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  // Field widths
  localparam int SAMPLE_W    = 10;
  localparam int MED_W       = 10;
  localparam int TDS_W       = 17;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Cubic in the median count m, scaled so the result is
  //   floor(P / (5 * 2^29)),  P = m*(m*(C3*m - C2) + C1)
  localparam int ACC_W       = 51;
  localparam int OPB_W       = 40;
  localparam int DROP_SHIFT  = 29;
  localparam int DIVQ_W      = 20;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 23;
  localparam int QUO_W       = DIVQ_W + RECIP_W;

  localparam logic signed [OPB_W-1:0] C3_K     = 40'sd333550;
  localparam logic signed [ACC_W-1:0] NEG_C2_K = -51'sd131000320;
  localparam logic signed [ACC_W-1:0] C1_K     = 51'sd89903857664;
  // ceil(2^23 / 5): exact divide by five for 20-bit values
  localparam logic [RECIP_W-1:0]      RECIP_K  = 21'd1677722;

  typedef enum logic [0:0] {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [SAMPLE_W-1:0]   sample;
  } item_t;

  typedef struct packed {
    logic                  store;
    logic                  start;
    logic [SAMPLE_W-1:0]   sample;
  } win_cmd_t;

  typedef struct packed {
    logic                  done;
    logic [MED_W-1:0]      median;
  } win_stat_t;

endpackage

FILE: rtl/mwt_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Short FIFO between the accepting front and the executing back part.
// ----------------------------------------------------------------------------
module mwt_queue
  import mwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/mwt_window.sv
// ----------------------------------------------------------------------------
// Sample window and rank selector
// Ring window of converter samples with one rank-count cell per entry; a
// compute sweep broadcasts each entry to all cells, then picks the two
// middle ranks and averages them.
// ----------------------------------------------------------------------------
module mwt_window
  import mwt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  win_cmd_t  cmd,
  output win_stat_t stat
);

  localparam logic [CNT_W-1:0] K_LO = CNT_W'((WINDOW_LEN - 1) / 2);
  localparam logic [CNT_W-1:0] K_HI = CNT_W'(WINDOW_LEN / 2);

  typedef enum logic [1:0] {
    W_IDLE,
    W_COUNT,
    W_FLAG,
    W_SELECT
  } win_state_t;

  win_state_t          state_r;
  logic [SAMPLE_W-1:0] win_r    [WINDOW_LEN];
  logic [IDX_W-1:0]    slot_r;
  logic [IDX_W-1:0]    sweep_r;
  logic [CNT_W-1:0]    lt_r     [WINDOW_LEN];
  logic [CNT_W-1:0]    le_r     [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] sel_lo_r;
  logic [WINDOW_LEN-1:0] sel_hi_r;
  logic [MED_W-1:0]    median_r;
  logic                done_r;
  logic [SAMPLE_W-1:0] bcast;
  logic [SAMPLE_W-1:0] lo_val;
  logic [SAMPLE_W-1:0] hi_val;
  logic [SAMPLE_W:0]   mid_sum;

  assign bcast   = win_r[sweep_r];
  assign mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
  assign stat    = '{done: done_r, median: median_r};

  // All entries of one rank hold the same value, so an OR picks it out.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      lo_val = lo_val | (win_r[i] & {SAMPLE_W{sel_lo_r[i]}});
      hi_val = hi_val | (win_r[i] & {SAMPLE_W{sel_hi_r[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      slot_r <= '0;
    end else if (cmd.store) begin
      win_r[slot_r] <= cmd.sample;
      slot_r <= (slot_r >= IDX_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      sweep_r  <= '0;
      done_r   <= 1'b0;
      median_r <= '0;
    end else begin
      done_r <= (state_r == W_SELECT);
      unique case (state_r)
        W_IDLE: begin
          if (cmd.start) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
              lt_r[i] <= '0;
              le_r[i] <= '0;
            end
            sweep_r <= '0;
            state_r <= W_COUNT;
          end
        end
        W_COUNT: begin
          // each cell counts entries below and at-or-below its own value
          for (int i = 0; i < WINDOW_LEN; i++) begin
            lt_r[i] <= lt_r[i] + CNT_W'(bcast < win_r[i]);
            le_r[i] <= le_r[i] + CNT_W'(bcast <= win_r[i]);
          end
          if (sweep_r == IDX_W'(WINDOW_LEN - 1)) begin
            state_r <= W_FLAG;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        W_FLAG: begin
          for (int i = 0; i < WINDOW_LEN; i++) begin
            sel_lo_r[i] <= (lt_r[i] <= K_LO) && (le_r[i] > K_LO);
            sel_hi_r[i] <= (lt_r[i] <= K_HI) && (le_r[i] > K_HI);
          end
          state_r <= W_SELECT;
        end
        W_SELECT: begin
          median_r <= mid_sum[SAMPLE_W:1];
          state_r  <= W_IDLE;
        end
        default: begin
          state_r <= W_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/mwt_back.sv
// ----------------------------------------------------------------------------
// Execution sequencer
// Takes items from the queue, drives the window, evaluates the cubic with
// one shared multiply-accumulate, holds the result and fills the output
// register.
// ----------------------------------------------------------------------------
module mwt_back
  import mwt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output win_cmd_t               win_cmd,
  input  win_stat_t              win_stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PAD_W = OUT_TDATA_W - TDS_W - MED_W;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WAIT,
    B_MAC0,
    B_MAC1,
    B_MAC2,
    B_RECIP,
    B_SCALE,
    B_OUT
  } back_state_t;

  back_state_t              state_r;
  logic [MED_W-1:0]         med_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [QUO_W-1:0]         quo_r;
  logic [TDS_W-1:0]         held_tds_r;
  logic [MED_W-1:0]         held_med_r;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;

  logic signed [OPB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic [DIVQ_W-1:0]        div_in;
  logic [TDS_W:0]           quo_top;
  logic [TDS_W-1:0]         tds_sat;
  logic                     take;

  assign take    = (state_r == B_IDLE) && q_valid;
  assign q_pop   = take;
  assign win_cmd = '{store:  take && (q_item.kind == OP_STORE),
                     start:  take && (q_item.kind == OP_COMPUTE),
                     sample: q_item.sample};

  // Horner steps: C3*m - C2, then m*a + C1, then m*b
  always_comb begin
    unique case (state_r)
      B_MAC0: begin
        mul_b  = C3_K;
        addend = NEG_C2_K;
      end
      B_MAC1: begin
        mul_b  = $signed(acc_r[OPB_W-1:0]);
        addend = C1_K;
      end
      default: begin
        mul_b  = $signed(acc_r[OPB_W-1:0]);
        addend = '0;
      end
    endcase
  end

  assign mul_p   = $signed({1'b0, med_r}) * mul_b;
  assign acc_nxt = mul_p + addend;
  assign div_in  = acc_r[DROP_SHIFT + DIVQ_W - 1 -: DIVQ_W];
  assign quo_top = quo_r[QUO_W-1 -: TDS_W + 1];
  assign tds_sat = quo_top[TDS_W] ? {TDS_W{1'b1}} : quo_top[TDS_W-1:0];

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      held_tds_r   <= '0;
      held_med_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop the valid once taken, unless a new item is loaded below
      if (out_tready && (state_r != B_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            state_r <= (q_item.kind == OP_COMPUTE) ? B_WAIT : B_OUT;
          end
        end
        B_WAIT: begin
          if (win_stat.done) begin
            med_r   <= win_stat.median;
            state_r <= B_MAC0;
          end
        end
        B_MAC0: begin
          acc_r   <= acc_nxt;
          state_r <= B_MAC1;
        end
        B_MAC1: begin
          acc_r   <= acc_nxt;
          state_r <= B_MAC2;
        end
        B_MAC2: begin
          acc_r   <= acc_nxt;
          state_r <= B_RECIP;
        end
        B_RECIP: begin
          quo_r   <= div_in * RECIP_K;
          state_r <= B_SCALE;
        end
        B_SCALE: begin
          held_tds_r <= tds_sat;
          held_med_r <= med_r;
          state_r    <= B_OUT;
        end
        B_OUT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {{PAD_W{1'b0}}, held_med_r, held_tds_r};
            out_tvalid_r <= 1'b1;
            state_r      <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/median_window_tds_converter.sv
// ----------------------------------------------------------------------------
// Median window dissolved-solids converter
// Keeps a ring window of converter samples and turns the window median into
// a dissolved-solids value in 1/16 ppm.
//
// Input stream: in_tuser[0] is the op (0 store sample, 1 compute), in_tdata
// carries the 10-bit sample. Every item returns one result on the output
// stream: the held value and the median it came from.
// A store item writes the sample into the next window slot; its result
// passes through the back part's B_OUT state into the output register.
// A compute item sweeps all WINDOW_LEN entries through per-entry rank
// counters (one entry per cycle), selects and averages the middle ranks, then
// runs three multiply-accumulate steps on one shared multiplier and a
// reciprocal scaling on a separate multiplier.
// The rank sweep sets the compute time; items are carried out one at a time.
// A two-item queue lets the input keep accepting while the back part works.
// Reset clears the window to zeros, the write slot, and the held value and
// median. A stalled output holds its result in the output register; the back
// part then waits and the queue fills before in_tready drops.
// ----------------------------------------------------------------------------
module median_window_tds_converter
  import mwt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] sample, [15:10] zero
  input  logic                   in_tuser,   // [0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [16:0] tds_sixteenths,
                                             // [26:17] median_count, [31:27] zero
);

  item_t     in_item;
  item_t     q_item;
  logic      q_valid;
  logic      q_pop;
  win_cmd_t  win_cmd;
  win_stat_t win_stat;

  // classify the incoming item
  assign in_item = '{kind:   op_kind_t'(in_tuser),
                     sample: in_tdata[SAMPLE_W-1:0]};

  mwt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  mwt_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (win_cmd),
    .stat  (win_stat)
  );

  mwt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .win_cmd    (win_cmd),
    .win_stat   (win_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
